@@ rtl/core/amegate_pkg.sv @@
// Shared constants for the motion event gate: widths, register indexes, reset values.
package amegate_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int TICK_W     = 32;
    localparam int PLAYER_W   = 8;
    localparam int THRESH_W   = 16;
    localparam int INTERVAL_W = 16;
    localparam int COOLDOWN_W = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_ADDR_W = 3;

    localparam int SQ_W       = 32;   // sum of three squares
    localparam int MAG_W      = 16;   // floor square root of SQ_W bits
    localparam int SUM_W      = 23;   // baseline accumulator
    localparam int CNT_W      = 7;    // baseline sample counter
    localparam int FILT_W     = 24;   // Q8 filtered level
    localparam int DVD_W      = 27;   // divider dividend / quotient
    localparam int DVS_W      = 7;    // divider divisor
    localparam int ROOT_REM_W = 19;   // root remainder
    localparam int STEP_W     = 5;    // shared iteration counter

    localparam int BASELINE_SAMPLES_DEF = 100;
    localparam logic [DVS_W-1:0] FILT_DIVISOR = DVS_W'(5);

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PLAYER_ID     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ENTER_THRESH  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_EXIT_THRESH   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SEND_INTERVAL = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SHOT_COOLDOWN = 3'd4;

    // reset values
    localparam logic [THRESH_W-1:0]   ENTER_THRESH_RST  = 16'd2048;
    localparam logic [THRESH_W-1:0]   EXIT_THRESH_RST   = 16'd614;
    localparam logic [INTERVAL_W-1:0] SEND_INTERVAL_RST = 16'd1000;
    localparam logic [COOLDOWN_W-1:0] SHOT_COOLDOWN_RST = 20'd10000;

endpackage

@@ rtl/core/accel_motion_event_gate_core.sv @@
// Motion event gate: IMU magnitude, gravity baseline, Q8 low-pass, hysteresis, rate limit.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------------
//   s_      | in        | s_valid / s_ready     | accel xyz, gyro xyz, now_tick, buttons
//   m_      | out       | m_valid / m_ready     | player, accel xyz, gyro xyz, left, shot
//   cfg_    | in        | cfg_we (no wait)      | cfg_addr selects register, cfg_wdata
//
// One beat at a time: s_ready is high only in idle. A tracked sample runs the
// multiply steps (one axis each), 16 root steps (2 bits a step), the magnitude
// state, 27 divider steps (1 quotient bit a step), then deviation, decision and,
// when it sends a result, the output load. A learning sample stops after the
// magnitude state; the last one also runs its divide by BASELINE_SAMPLES.
// Ignored samples (player 0) are accepted in idle and dropped.
// Reset is synchronous, active low; no clearing pass. The result sits in an
// output register, so a stalled m_ready only holds the block once a second
// result is ready.
module accel_motion_event_gate_core #(
    parameter int BASELINE_SAMPLES = amegate_pkg::BASELINE_SAMPLES_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   cfg_we,
    input  logic [amegate_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [amegate_pkg::CFG_DATA_W-1:0]     cfg_wdata,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [amegate_pkg::SAMPLE_W-1:0] s_accel_x,
    input  logic signed [amegate_pkg::SAMPLE_W-1:0] s_accel_y,
    input  logic signed [amegate_pkg::SAMPLE_W-1:0] s_accel_z,
    input  logic signed [amegate_pkg::SAMPLE_W-1:0] s_gyro_x,
    input  logic signed [amegate_pkg::SAMPLE_W-1:0] s_gyro_y,
    input  logic signed [amegate_pkg::SAMPLE_W-1:0] s_gyro_z,
    input  logic [amegate_pkg::TICK_W-1:0]         s_now_tick,
    input  logic                                   s_left_button,
    input  logic                                   s_right_button,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [amegate_pkg::PLAYER_W-1:0]       m_event_player,
    output logic signed [amegate_pkg::SAMPLE_W-1:0] m_out_accel_x,
    output logic signed [amegate_pkg::SAMPLE_W-1:0] m_out_accel_y,
    output logic signed [amegate_pkg::SAMPLE_W-1:0] m_out_accel_z,
    output logic signed [amegate_pkg::SAMPLE_W-1:0] m_out_gyro_x,
    output logic signed [amegate_pkg::SAMPLE_W-1:0] m_out_gyro_y,
    output logic signed [amegate_pkg::SAMPLE_W-1:0] m_out_gyro_z,
    output logic                                   m_left_pressed,
    output logic                                   m_shot_code
);
    import amegate_pkg::*;

    localparam logic [CNT_W-1:0] BASE_N = CNT_W'(BASELINE_SAMPLES);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ROOT = 3'd2;
    localparam logic [2:0] ST_MAG  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_DEV  = 3'd5;
    localparam logic [2:0] ST_DEC  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(2);
    localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(MAG_W - 1);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DVD_W - 1);

    // configuration registers
    logic [PLAYER_W-1:0]   player_id_reg;
    logic [THRESH_W-1:0]   enter_thresh_reg;
    logic [THRESH_W-1:0]   exit_thresh_reg;
    logic [INTERVAL_W-1:0] send_interval_reg;
    logic [COOLDOWN_W-1:0] shot_cooldown_reg;

    // persistent tracking state
    logic [SUM_W-1:0]  base_sum_reg,  base_sum_next;
    logic [CNT_W-1:0]  base_cnt_reg,  base_cnt_next;
    logic [FILT_W-1:0] filt_reg,      filt_next;
    logic              motion_reg,    motion_next;
    logic [TICK_W-1:0] last_emit_reg, last_emit_next;
    logic [TICK_W-1:0] last_shot_reg, last_shot_next;

    // sequencer and datapath
    logic [2:0]            state_reg,  state_next;
    logic [STEP_W-1:0]     step_reg,   step_next;
    logic [SQ_W-1:0]       acc_reg,    acc_next;      // sum of squares, then root radicand
    logic [MAG_W-1:0]      root_reg,   root_next;
    logic [ROOT_REM_W-1:0] rrem_reg,   rrem_next;
    logic [DVD_W-1:0]      dvd_reg,    dvd_next;      // dividend out, quotient in
    logic [DVS_W:0]        drem_reg,   drem_next;
    logic [DVS_W-1:0]      dvs_reg,    dvs_next;
    logic                  div_base_reg, div_base_next; // divide is the baseline average
    logic [TICK_W-1:0]     dev_reg,    dev_next;
    logic [TICK_W-1:0]     emit_dt_reg, emit_dt_next;
    logic [TICK_W-1:0]     shot_dt_reg, shot_dt_next;
    logic                  shot_code_reg, shot_code_next;

    // captured beat
    logic signed [SAMPLE_W-1:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg, gz_reg;
    logic [TICK_W-1:0]          now_reg;
    logic                       left_reg, right_reg;

    // output register
    logic                  m_valid_reg, m_valid_next;
    logic                  out_load;

    // combinational helpers
    logic signed [SAMPLE_W-1:0]   mul_op;
    logic signed [2*SAMPLE_W-1:0] mul_prod;
    logic [ROOT_REM_W-1:0]        rrem_sh, rtrial;
    logic                         root_ge;
    logic [DVS_W:0]               drem_sh;
    logic                         div_ge;
    logic [TICK_W-1:0]            base_q8, filt_wide;
    logic                         enter_hit, exit_hit, emit_ok, shot_ok;
    logic [SUM_W-1:0]             sum_add;
    logic [CNT_W-1:0]             cnt_inc;

    assign s_ready = (state_reg == ST_IDLE);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            player_id_reg     <= '0;
            enter_thresh_reg  <= ENTER_THRESH_RST;
            exit_thresh_reg   <= EXIT_THRESH_RST;
            send_interval_reg <= SEND_INTERVAL_RST;
            shot_cooldown_reg <= SHOT_COOLDOWN_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_PLAYER_ID:     player_id_reg     <= cfg_wdata[PLAYER_W-1:0];
                REG_ENTER_THRESH:  enter_thresh_reg  <= cfg_wdata[THRESH_W-1:0];
                REG_EXIT_THRESH:   exit_thresh_reg   <= cfg_wdata[THRESH_W-1:0];
                REG_SEND_INTERVAL: send_interval_reg <= cfg_wdata[INTERVAL_W-1:0];
                REG_SHOT_COOLDOWN: shot_cooldown_reg <= cfg_wdata[COOLDOWN_W-1:0];
                default: ;
            endcase
        end
    end

    // one shared 16x16 squarer, one axis per cycle
    always_comb begin
        case (step_reg[1:0])
            2'd0:    mul_op = ax_reg;
            2'd1:    mul_op = ay_reg;
            default: mul_op = az_reg;
        endcase
        mul_prod = mul_op * mul_op;
    end

    // root: two radicand bits per step
    assign rrem_sh = {rrem_reg[ROOT_REM_W-3:0], acc_reg[SQ_W-1 -: 2]};
    assign rtrial  = {1'b0, root_reg, 2'b01};
    assign root_ge = (rrem_sh >= rtrial);

    // restoring divider: one quotient bit per step
    assign drem_sh = {drem_reg[DVS_W-1:0], dvd_reg[DVD_W-1]};
    assign div_ge  = (drem_sh >= {1'b0, dvs_reg});

    assign sum_add   = base_sum_reg + SUM_W'(root_reg);
    assign cnt_inc   = base_cnt_reg + CNT_W'(1);
    assign base_q8   = {1'b0, base_sum_reg, 8'b0};
    assign filt_wide = TICK_W'(filt_reg);
    assign enter_hit = (dev_reg > {8'b0, enter_thresh_reg, 8'b0});
    assign exit_hit  = (dev_reg < {8'b0, exit_thresh_reg, 8'b0});
    assign emit_ok   = (emit_dt_reg >= TICK_W'(send_interval_reg));
    assign shot_ok   = !right_reg && (shot_dt_reg >= TICK_W'(shot_cooldown_reg));
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        root_next      = root_reg;
        rrem_next      = rrem_reg;
        dvd_next       = dvd_reg;
        drem_next      = drem_reg;
        dvs_next       = dvs_reg;
        div_base_next  = div_base_reg;
        dev_next       = dev_reg;
        emit_dt_next   = emit_dt_reg;
        shot_dt_next   = shot_dt_reg;
        shot_code_next = shot_code_reg;
        base_sum_next  = base_sum_reg;
        base_cnt_next  = base_cnt_reg;
        filt_next      = filt_reg;
        motion_next    = motion_reg;
        last_emit_next = last_emit_reg;
        last_shot_next = last_shot_reg;
        m_valid_next   = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                // unassigned player: beat is dropped with no state change
                if (s_valid && player_id_reg != '0) begin
                    state_next = ST_MUL;
                    step_next  = '0;
                    acc_next   = '0;
                end
            end
            ST_MUL: begin
                acc_next  = acc_reg + SQ_W'(unsigned'(mul_prod));
                step_next = step_reg + STEP_W'(1);
                if (step_reg == MUL_LAST) begin
                    state_next = ST_ROOT;
                    step_next  = '0;
                    root_next  = '0;
                    rrem_next  = '0;
                end
            end
            ST_ROOT: begin
                acc_next  = {acc_reg[SQ_W-3:0], 2'b00};
                rrem_next = root_ge ? rrem_sh - rtrial : rrem_sh;
                root_next = {root_reg[MAG_W-2:0], root_ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == ROOT_LAST) begin
                    state_next = ST_MAG;
                end
            end
            ST_MAG: begin
                step_next = '0;
                drem_next = '0;
                if (base_cnt_reg < BASE_N) begin
                    // learning: accumulate, average once the count is reached
                    base_sum_next = sum_add;
                    base_cnt_next = cnt_inc;
                    if (cnt_inc == BASE_N) begin
                        state_next    = ST_DIV;
                        div_base_next = 1'b1;
                        dvs_next      = BASE_N;
                        dvd_next      = DVD_W'(sum_add);
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    // filter numerator 4*old + 256*mag, divided by five
                    state_next    = ST_DIV;
                    div_base_next = 1'b0;
                    dvs_next      = FILT_DIVISOR;
                    dvd_next      = {1'b0, filt_reg, 2'b00} + {3'b0, root_reg, 8'b0};
                    emit_dt_next  = now_reg - last_emit_reg;
                    shot_dt_next  = now_reg - last_shot_reg;
                end
            end
            ST_DIV: begin
                drem_next = div_ge ? drem_sh - {1'b0, dvs_reg} : drem_sh;
                dvd_next  = {dvd_reg[DVD_W-2:0], div_ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == DIV_LAST) begin
                    if (div_base_reg) begin
                        base_sum_next = dvd_next[SUM_W-1:0];
                        state_next    = ST_IDLE;
                    end else begin
                        filt_next  = dvd_next[FILT_W-1:0];
                        state_next = ST_DEV;
                    end
                end
            end
            ST_DEV: begin
                dev_next   = (filt_wide >= base_q8) ? filt_wide - base_q8
                                                    : base_q8 - filt_wide;
                state_next = ST_DEC;
            end
            ST_DEC: begin
                state_next = ST_IDLE;
                // hysteresis; the sample that ends motion may still send
                if (!motion_reg && enter_hit) begin
                    motion_next = 1'b1;
                end else if (motion_reg && exit_hit) begin
                    motion_next = 1'b0;
                end
                if ((motion_reg || enter_hit) && emit_ok) begin
                    last_emit_next = now_reg;
                    shot_code_next = !shot_ok;
                    if (shot_ok) begin
                        last_shot_next = now_reg;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            base_sum_reg  <= '0;
            base_cnt_reg  <= '0;
            filt_reg      <= '0;
            motion_reg    <= 1'b0;
            last_emit_reg <= '0;
            last_shot_reg <= '0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            base_sum_reg  <= base_sum_next;
            base_cnt_reg  <= base_cnt_next;
            filt_reg      <= filt_next;
            motion_reg    <= motion_next;
            last_emit_reg <= last_emit_next;
            last_shot_reg <= last_shot_next;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge aclk) begin
        step_reg      <= step_next;
        acc_reg       <= acc_next;
        root_reg      <= root_next;
        rrem_reg      <= rrem_next;
        dvd_reg       <= dvd_next;
        drem_reg      <= drem_next;
        dvs_reg       <= dvs_next;
        div_base_reg  <= div_base_next;
        dev_reg       <= dev_next;
        emit_dt_reg   <= emit_dt_next;
        shot_dt_reg   <= shot_dt_next;
        shot_code_reg <= shot_code_next;
        if (s_valid && s_ready) begin
            ax_reg    <= s_accel_x;
            ay_reg    <= s_accel_y;
            az_reg    <= s_accel_z;
            gx_reg    <= s_gyro_x;
            gy_reg    <= s_gyro_y;
            gz_reg    <= s_gyro_z;
            now_reg   <= s_now_tick;
            left_reg  <= s_left_button;
            right_reg <= s_right_button;
        end
        if (out_load) begin
            m_event_player <= player_id_reg;
            m_out_accel_x  <= ax_reg;
            m_out_accel_y  <= ay_reg;
            m_out_accel_z  <= az_reg;
            m_out_gyro_x   <= gx_reg;
            m_out_gyro_y   <= gy_reg;
            m_out_gyro_z   <= gz_reg;
            m_left_pressed <= left_reg;
            m_shot_code    <= shot_code_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
